[hdl/rie_pkg.sv]
// Package for the RV32I encoder: beat types, mnemonic codes, opcode and funct tables.
`default_nettype none
package rie_pkg;

    localparam int unsigned MNEM_W = 5;
    localparam int unsigned REG_W  = 5;
    localparam int unsigned XLEN   = 32;
    localparam int unsigned OFF_W  = XLEN + 2;

    // mnemonic index boundaries and special members
    localparam logic [MNEM_W-1:0] MN_FIRST_I = 5'd12;
    localparam logic [MNEM_W-1:0] MN_LB      = 5'd15;
    localparam logic [MNEM_W-1:0] MN_JALR    = 5'd19;
    localparam logic [MNEM_W-1:0] MN_FIRST_S = 5'd20;
    localparam logic [MNEM_W-1:0] MN_FIRST_B = 5'd24;
    localparam logic [MNEM_W-1:0] MN_AUIPC   = 5'd28;
    localparam logic [MNEM_W-1:0] MN_JAL     = 5'd30;
    localparam int unsigned       MNEM_COUNT = 31;

    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] F7_ALT     = 7'b0100000;
    localparam logic [6:0] F7_MULDIV  = 7'b0000001;
    localparam logic [6:0] F7_BASE    = 7'b0000000;

    localparam logic signed [XLEN-1:0] U_IMM_MAX = 32'sd1048575;

    localparam logic [2:0] F3_TAB [MNEM_COUNT] = '{
        3'd0, 3'd7, 3'd6, 3'd1, 3'd2, 3'd5, 3'd5, 3'd0, 3'd4, 3'd0, 3'd4, 3'd6,
        3'd0, 3'd7, 3'd6, 3'd0, 3'd3, 3'd1, 3'd2, 3'd0,
        3'd0, 3'd1, 3'd2, 3'd3,
        3'd0, 3'd1, 3'd4, 3'd5,
        3'd0, 3'd0,
        3'd0
    };

    localparam logic [6:0] F7_TAB [12] = '{
        F7_BASE, F7_BASE, F7_BASE, F7_BASE, F7_BASE, F7_ALT,
        F7_BASE, F7_ALT, F7_BASE, F7_MULDIV, F7_MULDIV, F7_MULDIV
    };

    typedef enum logic [2:0] {
        FMT_R,
        FMT_I,
        FMT_S,
        FMT_B,
        FMT_U,
        FMT_J,
        FMT_BAD
    } fmt_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RANGE    = 2'd1,
        STATUS_MISALIGN = 2'd2
    } status_t;

    typedef struct packed {
        logic [MNEM_W-1:0]      mnemonic;
        logic [REG_W-1:0]       dest_reg;
        logic [REG_W-1:0]       src1_reg;
        logic [REG_W-1:0]       src2_reg;
        logic signed [XLEN-1:0] immediate;
        logic                   is_label;
    } item_t;

    typedef struct packed {
        logic [XLEN-1:0] instr_address;
        logic [XLEN-1:0] machine_word;
        status_t         status;
    } result_t;

    function automatic fmt_t decode_fmt(input logic [MNEM_W-1:0] mn);
        fmt_t f;
        if (mn < MN_FIRST_I)
            f = FMT_R;
        else if (mn < MN_FIRST_S)
            f = FMT_I;
        else if (mn < MN_FIRST_B)
            f = FMT_S;
        else if (mn < MN_AUIPC)
            f = FMT_B;
        else if (mn < MN_JAL)
            f = FMT_U;
        else if (mn == MN_JAL)
            f = FMT_J;
        else
            f = FMT_BAD;
        return f;
    endfunction

endpackage
`default_nettype wire

[hdl/riscv_instruction_encoder.sv]
// Top level of the RV32I encoder: input register, text address counter, result register.
`default_nettype none
// Encodes one parsed RV32I instruction per beat into its machine word and text address.
// An accepted item beat goes through the input register, then the result register, to
// the result beat; a new item is taken every cycle while results flow. The text
// address counter starts at zero, advances by 4 on each successful encode and holds on
// an error, which returns a zero word and a nonzero status. Branch and jal offsets with
// is_label set are taken relative to the counter at that instruction.
module riscv_instruction_encoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  rie_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output rie_pkg::result_t result
);
    import rie_pkg::*;

    logic        hold_valid_reg;
    logic        hold_valid_next;
    item_t       hold_reg;
    logic        result_valid_reg;
    logic        result_valid_next;
    result_t     result_reg;
    logic [31:0] text_address_reg;
    logic [31:0] text_address_next;
    logic        result_free;
    logic        advance;
    logic        take_item;
    logic [31:0] enc_word;
    status_t     enc_status;

    rie_encoder u_encoder (
        .item         (hold_reg),
        .text_address (text_address_reg),
        .machine_word (enc_word),
        .status       (enc_status)
    );

    assign result_free = !result_valid_reg || !result_stall;
    assign advance     = hold_valid_reg && result_free;
    assign item_stall  = hold_valid_reg && !result_free;
    assign take_item   = item_valid && !item_stall;

    assign hold_valid_next   = take_item || (hold_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && result_stall);
    assign text_address_next = (advance && enc_status == STATUS_OK)
                               ? text_address_reg + 32'd4 : text_address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            text_address_reg <= 32'd0;
        end
        else
        begin
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
            text_address_reg <= text_address_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
            hold_reg <= item;
        if (advance)
        begin
            result_reg.instr_address <= text_address_reg;
            result_reg.machine_word  <= enc_word;
            result_reg.status        <= enc_status;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

[hdl/rie_encoder.sv]
// Combinational encode of one instruction beat against the current text address.
`default_nettype none
module rie_encoder (
    input  rie_pkg::item_t        item,
    input  logic [31:0]           text_address,
    output logic [31:0]           machine_word,
    output rie_pkg::status_t      status
);
    import rie_pkg::*;

    fmt_t              fmt;
    logic [6:0]        opcode;
    logic [2:0]        funct3;
    logic [6:0]        funct7;
    logic [OFF_W-1:0]  imm_ext;
    logic [OFF_W-1:0]  offset;
    logic [11:0]       imm12;
    logic              imm12_ok;
    logic              branch_ok;
    logic              jal_ok;
    logic              u_ok;
    logic [31:0]       word;
    status_t           stat;

    assign fmt     = decode_fmt(item.mnemonic);
    assign funct3  = (fmt == FMT_BAD) ? 3'd0 : F3_TAB[item.mnemonic];
    assign funct7  = (fmt == FMT_R) ? F7_TAB[item.mnemonic[3:0]] : F7_BASE;
    assign imm_ext = {{2{item.immediate[XLEN-1]}}, item.immediate};
    assign offset  = item.is_label ? (imm_ext - {2'b00, text_address}) : imm_ext;
    assign imm12   = item.immediate[11:0];

    assign imm12_ok  = (&item.immediate[31:11]) | ~(|item.immediate[31:11]);
    assign branch_ok = (&offset[OFF_W-1:12]) | ~(|offset[OFF_W-1:12]);
    assign jal_ok    = (&offset[OFF_W-1:20]) | ~(|offset[OFF_W-1:20]);
    assign u_ok      = !item.immediate[XLEN-1] && (item.immediate <= U_IMM_MAX);

    always_comb
    begin
        case (fmt)
            FMT_R:   opcode = OPC_OP;
            FMT_I:
            begin
                if (item.mnemonic == MN_JALR)
                    opcode = OPC_JALR;
                else if (item.mnemonic >= MN_LB)
                    opcode = OPC_LOAD;
                else
                    opcode = OPC_OPIMM;
            end
            FMT_S:   opcode = OPC_STORE;
            FMT_B:   opcode = OPC_BRANCH;
            FMT_U:   opcode = (item.mnemonic == MN_AUIPC) ? OPC_AUIPC : OPC_LUI;
            FMT_J:   opcode = OPC_JAL;
            default: opcode = 7'd0;
        endcase
    end

    always_comb
    begin
        word = 32'd0;
        stat = STATUS_OK;
        case (fmt)
            FMT_R:
                word = {funct7, item.src2_reg, item.src1_reg, funct3, item.dest_reg, opcode};
            FMT_I:
            begin
                if (!imm12_ok)
                    stat = STATUS_RANGE;
                else
                    word = {imm12, item.src1_reg, funct3, item.dest_reg, opcode};
            end
            FMT_S:
            begin
                if (!imm12_ok)
                    stat = STATUS_RANGE;
                else
                    word = {imm12[11:5], item.src2_reg, item.src1_reg, funct3,
                            imm12[4:0], opcode};
            end
            FMT_B:
            begin
                if (!branch_ok)
                    stat = STATUS_RANGE;
                else if (offset[0])
                    stat = STATUS_MISALIGN;
                else
                    word = {offset[12], offset[10:5], item.src2_reg, item.src1_reg,
                            funct3, offset[4:1], offset[11], opcode};
            end
            FMT_U:
            begin
                if (!u_ok)
                    stat = STATUS_RANGE;
                else
                    word = {item.immediate[19:0], item.dest_reg, opcode};
            end
            FMT_J:
            begin
                if (!jal_ok)
                    stat = STATUS_RANGE;
                else if (offset[0])
                    stat = STATUS_MISALIGN;
                else
                    word = {offset[20], offset[10:1], offset[11], offset[19:12],
                            item.dest_reg, opcode};
            end
            default:
                stat = STATUS_RANGE;
        endcase
    end

    assign machine_word = word;
    assign status       = stat;

endmodule
`default_nettype wire

[hdl/rie_checker.sv]
// Port-level checker for the RV32I encoder and its bind to the top level.
`default_nettype none
module rie_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             result_valid,
    input  logic             result_stall,
    input  rie_pkg::result_t result
);
    import rie_pkg::*;

    logic        result_beat;
    logic [31:0] expect_addr_reg;
    logic [31:0] expect_addr_next;

    assign result_beat      = result_valid && !result_stall;
    assign expect_addr_next = !result_beat ? expect_addr_reg
                            : (result.status == STATUS_OK) ? result.instr_address + 32'd4
                            : result.instr_address;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expect_addr_reg <= 32'd0;
        else
            expect_addr_reg <= expect_addr_next;
    end

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != STATUS_OK |-> result.machine_word == 32'd0)
        else $error("nonzero word on error");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.instr_address[1:0] == 2'b00)
        else $error("misaligned text address");

    // address advances by 4 only after a good beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.instr_address == expect_addr_reg)
        else $error("text address out of sequence");

endmodule

bind riscv_instruction_encoder rie_checker u_rie_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire

[bench/riscv_instruction_encoder_test.sv]
// Self-checking testbench for the RV32I instruction encoder with its text address counter.
`timescale 1ns / 1ps

module riscv_instruction_encoder_test;

    import rie_pkg::*;

    typedef enum logic [4:0] {
        INS_ADD, INS_AND, INS_OR, INS_SLL, INS_SLT, INS_SRA, INS_SRL, INS_SUB,
        INS_XOR, INS_MUL, INS_DIV, INS_REM,
        INS_ADDI, INS_ANDI, INS_ORI, INS_LB, INS_LD, INS_LH, INS_LW, INS_JALR,
        INS_SB, INS_SH, INS_SW, INS_SD,
        INS_BEQ, INS_BNE, INS_BLT, INS_BGE,
        INS_AUIPC, INS_LUI,
        INS_JAL,
        INS_NONE
    } instr_e;

    localparam logic [2:0] FUNCT3_OF [32] = '{
        3'd0, 3'd7, 3'd6, 3'd1, 3'd2, 3'd5, 3'd5, 3'd0, 3'd4, 3'd0, 3'd4, 3'd6,
        3'd0, 3'd7, 3'd6, 3'd0, 3'd3, 3'd1, 3'd2, 3'd0,
        3'd0, 3'd1, 3'd2, 3'd3,
        3'd0, 3'd1, 3'd4, 3'd5,
        3'd0, 3'd0,
        3'd0,
        3'd0
    };

    function automatic fmt_t fmt_of(input instr_e mn);
        fmt_t f;
        if (mn <= INS_REM)
            f = FMT_R;
        else if (mn <= INS_JALR)
            f = FMT_I;
        else if (mn <= INS_SD)
            f = FMT_S;
        else if (mn <= INS_BGE)
            f = FMT_B;
        else if (mn <= INS_LUI)
            f = FMT_U;
        else if (mn == INS_JAL)
            f = FMT_J;
        else
            f = FMT_BAD;
        return f;
    endfunction

    // legal immediate or offset window per format
    function automatic void imm_bounds(input fmt_t f, output longint lo, output longint hi);
        case (f)
            FMT_I, FMT_S:
            begin
                lo = -2048;
                hi = 2047;
            end
            FMT_B:
            begin
                lo = -4096;
                hi = 4095;
            end
            FMT_U:
            begin
                lo = 0;
                hi = U_IMM_MAX;
            end
            FMT_J:
            begin
                lo = -1048576;
                hi = 1048575;
            end
            default:
            begin
                lo = -(64'sd1 <<< 31);
                hi = (64'sd1 <<< 31) - 1;
            end
        endcase
    endfunction

    class encoding_checker;
        logic [31:0] next_address;
        result_t     expected_encodings[$];
        int          mismatch_count;

        function new();
            next_address = '0;
            mismatch_count = 0;
        endfunction

        function result_t encode_instr(item_t it);
            result_t     r;
            instr_e      mn;
            fmt_t        f;
            longint      lo, hi, v;
            logic [31:0] word;
            logic [20:0] u;
            logic [2:0]  f3;
            logic [6:0]  f7, opc;
            status_t     st;
            mn = instr_e'(it.mnemonic);
            f = fmt_of(mn);
            imm_bounds(f, lo, hi);
            f3 = FUNCT3_OF[mn];
            v = longint'($signed(it.immediate));
            if ((f == FMT_B || f == FMT_J) && it.is_label)
                v = v - longint'({32'b0, next_address});
            u = v[20:0];
            word = '0;
            st = STATUS_OK;
            case (f)
                FMT_R:
                begin
                    case (mn)
                        INS_SRA, INS_SUB:           f7 = F7_ALT;
                        INS_MUL, INS_DIV, INS_REM:  f7 = F7_MULDIV;
                        default:                    f7 = F7_BASE;
                    endcase
                    word = {f7, it.src2_reg, it.src1_reg, f3, it.dest_reg, OPC_OP};
                end
                FMT_BAD:
                    st = STATUS_RANGE;
                default:
                begin
                    if (v < lo || v > hi)
                        st = STATUS_RANGE;
                    else if ((f == FMT_B || f == FMT_J) && v[0])
                        st = STATUS_MISALIGN;
                    else
                    begin
                        case (f)
                            FMT_I:
                            begin
                                opc = (mn == INS_JALR) ? OPC_JALR :
                                      (mn >= INS_LB) ? OPC_LOAD : OPC_OPIMM;
                                word = {u[11:0], it.src1_reg, f3, it.dest_reg, opc};
                            end
                            FMT_S:
                                word = {u[11:5], it.src2_reg, it.src1_reg, f3, u[4:0],
                                        OPC_STORE};
                            FMT_B:
                                word = {u[12], u[10:5], it.src2_reg, it.src1_reg, f3,
                                        u[4:1], u[11], OPC_BRANCH};
                            FMT_U:
                                word = {u[19:0], it.dest_reg,
                                        (mn == INS_LUI) ? OPC_LUI : OPC_AUIPC};
                            default:
                                word = {u[20], u[10:1], u[11], u[19:12], it.dest_reg,
                                        OPC_JAL};
                        endcase
                    end
                end
            endcase
            r.instr_address = next_address;
            r.machine_word = word;
            r.status = st;
            if (st == STATUS_OK)
                next_address = next_address + 32'd4;
            return r;
        endfunction

        function void note_instr(item_t it);
            expected_encodings.insert(expected_encodings.size(), encode_instr(it));
        endfunction

        function int pending();
            return expected_encodings.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
            mismatch_count++;
        endtask

        task check_encoding(result_t got);
            result_t want;
            if (expected_encodings.size() == 0)
            begin
                report_mismatch("unexpected result beat", got.machine_word, '0);
                return;
            end
            want = expected_encodings.pop_front();
            if (got.instr_address !== want.instr_address)
                report_mismatch("instr_address", got.instr_address, want.instr_address);
            if (got.machine_word !== want.machine_word)
                report_mismatch("machine_word", got.machine_word, want.machine_word);
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    localparam int RANDOM_ITEMS = 1406;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    encoding_checker sb = new();
    int      accepted_count = 0;
    int      burst_left = 0;
    bit      hold_active = 1'b0;
    bit      hold_done = 1'b0;
    bit      stim_done = 1'b0;

    riscv_instruction_encoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic item_t make_instr(input instr_e mn, input logic [4:0] rd,
                                         input logic [4:0] rs1, input logic [4:0] rs2,
                                         input longint imm, input bit lab);
        item_t it;
        it.mnemonic = mn;
        it.dest_reg = rd;
        it.src1_reg = rs1;
        it.src2_reg = rs2;
        it.immediate = imm[31:0];
        it.is_label = lab;
        return it;
    endfunction

    // mostly in-window values, some window edges, some raw 32-bit noise
    function automatic item_t random_instr(input logic [31:0] pc);
        item_t  it;
        fmt_t   f;
        longint lo, hi, v;
        it.mnemonic = ($urandom_range(0, 47) == 0) ? INS_NONE : 5'($urandom_range(0, 30));
        it.dest_reg = 5'($urandom);
        it.src1_reg = 5'($urandom);
        it.src2_reg = 5'($urandom);
        it.is_label = 1'($urandom);
        f = fmt_of(instr_e'(it.mnemonic));
        imm_bounds(f, lo, hi);
        case ($urandom_range(0, 9))
            0:
                v = longint'($signed(32'($urandom)));
            1:
                case ($urandom_range(0, 5))
                    0:       v = lo - 1;
                    1:       v = lo;
                    2:       v = lo + 1;
                    3:       v = hi - 1;
                    4:       v = hi;
                    default: v = hi + 1;
                endcase
            default:
            begin
                v = lo + longint'($urandom_range(0, 32'(hi - lo)));
                if (f == FMT_B || f == FMT_J)
                    v[0] = 1'b0;
            end
        endcase
        if (it.is_label && (f == FMT_B || f == FMT_J))
            v = v + longint'(pc);
        it.immediate = v[31:0];
        return it;
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_instr(input item_t it, input bit drain_after);
        int gap;
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_instr(it);
        accepted_count++;
        @(negedge clk);
        if (drain_after)
        begin
            item_valid <= 1'b0;
            do
                @(negedge clk);
            while (sb.pending() != 0);
        end
        else if (burst_left > 0 || hold_active)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 8);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 24);
        end
    endtask

    task automatic directed_items();
        longint lo, hi;
        for (int m = 0; m < 32; m++)
        begin
            imm_bounds(fmt_of(instr_e'(m)), lo, hi);
            send_instr(make_instr(instr_e'(m), m[0] ? 5'd31 : 5'd0, m[0] ? 5'd0 : 5'd31,
                                  5'(m), m[0] ? hi : lo, 1'b0), 1'b0);
        end
        send_instr(make_instr(INS_ADDI, 5'd1, 5'd2, 5'd3, 2048, 1'b0), 1'b0);
        send_instr(make_instr(INS_SW, 5'd4, 5'd5, 5'd6, -2049, 1'b0), 1'b0);
        send_instr(make_instr(INS_BEQ, 5'd0, 5'd7, 5'd8, 4094, 1'b0), 1'b0);
        // out of range and odd together
        send_instr(make_instr(INS_BNE, 5'd0, 5'd9, 5'd10, 4097, 1'b0), 1'b0);
        send_instr(make_instr(INS_BLT, 5'd0, 5'd11, 5'd12,
                              longint'(sb.next_address) + 8, 1'b1), 1'b0);
        send_instr(make_instr(INS_BGE, 5'd0, 5'd13, 5'd14,
                              longint'(sb.next_address) + 4095, 1'b1), 1'b0);
        send_instr(make_instr(INS_JAL, 5'd1, 5'd0, 5'd0, 1048575, 1'b0), 1'b0);
        send_instr(make_instr(INS_JAL, 5'd31, 5'd0, 5'd0,
                              longint'(sb.next_address) - 1048576, 1'b1), 1'b0);
        send_instr(make_instr(INS_JAL, 5'd2, 5'd0, 5'd0, 64'h8000_0000, 1'b0), 1'b0);
        send_instr(make_instr(INS_LUI, 5'd5, 5'd0, 5'd0, -1, 1'b0), 1'b0);
        send_instr(make_instr(INS_AUIPC, 5'd6, 5'd0, 5'd0, 1048576, 1'b0), 1'b0);
        // label flag on formats that ignore it
        send_instr(make_instr(INS_ADD, 5'd7, 5'd8, 5'd9, -1, 1'b1), 1'b0);
        send_instr(make_instr(INS_LW, 5'd10, 5'd11, 5'd0, 17, 1'b1), 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_encoding(result);
    end

    // receiver stall pattern, with one long hold-off once traffic is flowing
    initial
    begin
        int unsigned span, pct;
        wait (rst_n === 1'b1);
        while (!stim_done)
        begin
            if (!hold_done && accepted_count >= 400)
            begin
                hold_active = 1'b1;
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (60) @(negedge clk);
                hold_active = 1'b0;
                hold_done = 1'b1;
            end
            else
            begin
                span = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0:       pct = 0;
                    1:       pct = 30;
                    default: pct = 75;
                endcase
                while (span > 0 && !stim_done)
                begin
                    @(negedge clk);
                    result_stall <= ($urandom_range(0, 99) < pct);
                    span--;
                end
            end
        end
        @(negedge clk);
        result_stall <= 1'b0;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed_items();
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_instr(random_instr(sb.next_address), n == 600 || n == RANDOM_ITEMS - 1);
        stim_done = 1'b1;
        repeat (10) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/rie_pkg.sv
hdl/rie_encoder.sv
hdl/riscv_instruction_encoder.sv
hdl/rie_checker.sv
bench/riscv_instruction_encoder_test.sv
